// File: rtl/omp_pkg.sv
// Shared types and constants for the object message parser.
package omp_pkg;

   localparam logic [1:0] MAX_INDEXES      = 2'd3;

   localparam logic [1:0] CSR_VERSION      = 2'd0;
   localparam logic [1:0] CSR_DISTRICT     = 2'd1;
   localparam logic [1:0] CSR_INTERSECTION = 2'd2;

   localparam logic [2:0] POS_VERSION      = 3'd1;
   localparam logic [2:0] POS_DISTRICT     = 3'd5;
   localparam logic [2:0] POS_INTERSECTION = 3'd6;
   localparam logic [2:0] POS_COUNT        = 3'd7;

   localparam logic [7:0] COUNT_MASK       = 8'h70;

   localparam int RSP_DATA_BITS = 48;

   typedef struct packed {
      logic [7:0] version;
      logic [7:0] district;
      logic [7:0] intersection;
   } cfg_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [7:0] object_value;
      logic [7:0] index_two;
      logic [7:0] index_one;
      logic [7:0] index_zero;
      logic [1:0] index_count;
      logic [7:0] object_type;
   } record_type;

   localparam int RECORD_BITS = $bits(record_type);

endpackage

// File: rtl/omp_csr.sv
// Configuration registers: expected version, district and intersection.
module omp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data,
   output omp_pkg::cfg_type  cfg
);
   import omp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VERSION:      cfg_in.version      = csr_data;
            CSR_DISTRICT:     cfg_in.district     = csr_data;
            CSR_INTERSECTION: cfg_in.intersection = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version      <= 8'd1;
         cfg_ff.district     <= 8'd0;
         cfg_ff.intersection <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// File: rtl/omp_parser.sv
// Byte-serial header check and object record assembly.
module omp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           data_byte,
   input  logic                 start_of_message,
   input  omp_pkg::cfg_type     cfg,
   output logic                 rec_valid,
   output omp_pkg::record_type  rec
);
   import omp_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_TYPE, PH_COUNT, PH_INDEX, PH_VALUE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] header_pos_ff, header_pos_in;
   logic [3:0] objects_left_ff, objects_left_in;
   logic [1:0] indexes_left_ff, indexes_left_in;
   logic [7:0] held_type_ff, held_type_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_idx_ff [3];
   logic [7:0] held_idx_in [3];
   logic [1:0] slot;
   logic [7:0] count_bits;
   logic       mismatch;

   always_comb begin
      phase_in        = phase_ff;
      header_pos_in   = header_pos_ff;
      objects_left_in = objects_left_ff;
      indexes_left_in = indexes_left_ff;
      held_type_in    = held_type_ff;
      held_count_in   = held_count_ff;
      held_idx_in     = held_idx_ff;
      rec_valid       = 1'b0;
      slot            = held_count_ff - indexes_left_ff;
      count_bits      = data_byte & COUNT_MASK;
      mismatch        = 1'b0;

      if (take) begin
         if (start_of_message) begin
            phase_in        = PH_HEADER;
            header_pos_in   = 3'd0;
            objects_left_in = 4'd0;
            indexes_left_in = 2'd0;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  header_pos_in = header_pos_ff + 3'd1;
                  mismatch = (header_pos_in == POS_VERSION && data_byte != cfg.version)
                     || (header_pos_in == POS_DISTRICT && data_byte != cfg.district)
                     || (header_pos_in == POS_INTERSECTION
                         && data_byte != cfg.intersection);
                  if (mismatch) begin
                     phase_in = PH_IDLE;
                  end else if (header_pos_in == POS_COUNT) begin
                     objects_left_in = {1'b0, count_bits[6:4]} + 4'd1;
                     phase_in        = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  held_type_in   = data_byte;
                  held_idx_in[0] = 8'd0;
                  held_idx_in[1] = 8'd0;
                  held_idx_in[2] = 8'd0;
                  phase_in       = PH_COUNT;
               end
               PH_COUNT: begin
                  held_count_in = data_byte[7:6];
                  if (held_count_in > MAX_INDEXES) begin
                     phase_in = PH_IDLE;
                  end else if (held_count_in == 2'd0) begin
                     phase_in = PH_VALUE;
                  end else begin
                     indexes_left_in = held_count_in;
                     phase_in        = PH_INDEX;
                  end
               end
               PH_INDEX: begin
                  if (slot != 2'd3) begin
                     held_idx_in[slot] = data_byte;
                  end
                  indexes_left_in = indexes_left_ff - 2'd1;
                  if (indexes_left_in == 2'd0) begin
                     phase_in = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  rec_valid       = 1'b1;
                  objects_left_in = objects_left_ff - 4'd1;
                  phase_in        = (objects_left_in == 4'd0) ? PH_IDLE : PH_TYPE;
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         header_pos_ff   <= 3'd0;
         objects_left_ff <= 4'd0;
         indexes_left_ff <= 2'd0;
      end else begin
         phase_ff        <= phase_in;
         header_pos_ff   <= header_pos_in;
         objects_left_ff <= objects_left_in;
         indexes_left_ff <= indexes_left_in;
      end
      held_type_ff  <= held_type_in;
      held_count_ff <= held_count_in;
      held_idx_ff   <= held_idx_in;
   end

   assign rec.object_type  = held_type_ff;
   assign rec.index_count  = held_count_ff;
   assign rec.index_zero   = held_idx_ff[0];
   assign rec.index_one    = held_idx_ff[1];
   assign rec.index_two    = held_idx_ff[2];
   assign rec.object_value = data_byte;

endmodule

// File: rtl/omp_out_buf.sv
// Two-entry result buffer between the parser and the result channel.
module omp_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  omp_pkg::record_type  wr_rec,
   output logic                 full,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output omp_pkg::record_type  rd_rec
);
   import omp_pkg::*;

   record_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push = wr_valid && !full;
   assign pop  = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   assign full     = count_ff[1];
   assign rd_valid = count_ff != 2'd0;
   assign rd_rec   = mem_ff[rd_ptr_ff];

endmodule

// File: rtl/object_message_parser.sv
// Object message parser: byte stream in, object records out.
//
// Usage:
//   req_*  : one message byte a word; tuser high marks byte 0 of a message
//            and restarts parsing from any point.
//   rsp_*  : one object record for each object's value byte.
//   csr_*  : register writes (0 version, 1 district, 2 intersection), always
//            ready, to be done while no message is in flight.
// Timing: a byte enters an input register and is parsed from it; the record
// of a value byte is written into a two-word output buffer, which drives
// rsp_tvalid. One byte is taken every cycle while the output buffer is not
// full.
// Reset clears the parser to idle (bytes ignored until a start word), empties
// the output buffer and loads version 1, district 0, intersection 0.
// When the receiver stalls, the output buffer fills, the input register holds
// and req_tready drops; no record is lost.
module object_message_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] object_type, [9:8] index_count, [17:10] index_zero,
   // [25:18] index_one, [33:26] index_two, [41:34] object_value, rest zero
   output logic [omp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import omp_pkg::*;

   cfg_type    cfg;
   record_type rec, rsp_rec;
   logic       rec_valid, buf_full, take;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   assign take       = in_valid_ff && !buf_full;
   assign req_tready = !in_valid_ff || !buf_full;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   omp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   omp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .data_byte        (in_byte_ff),
      .start_of_message (in_start_ff),
      .cfg              (cfg),
      .rec_valid        (rec_valid),
      .rec              (rec)
   );

   omp_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (rec_valid),
      .wr_rec   (rec),
      .full     (buf_full),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_rec   (rsp_rec)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-RECORD_BITS){1'b0}}, rsp_rec};

endmodule

// File: bench/tb_top.sv
// Testbench for the object message parser: byte streams in, object records checked.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import omp_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_HEADER, SCAN_TYPE, SCAN_COUNT, SCAN_INDEX, SCAN_VALUE
   } scan_phase_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   // parser copy
   logic [7:0] want_version = 8'd1;
   logic [7:0] want_district = 8'd0;
   logic [7:0] want_intersection = 8'd0;
   scan_phase_type scan_phase = SCAN_IDLE;
   logic [2:0] header_pos = '0;
   logic [3:0] objects_left = '0;
   logic [1:0] indexes_left = '0;
   record_type held = '0;
   record_type pending_records[$];

   int errors = 0;
   int idle_pct = 0;
   int stall_left = 0;
   int bytes_sent = 0;

   object_message_parser uut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int idle_length();
      if ($urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 8);
      return $urandom_range(3, 1);
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic sop);
      logic [1:0] slot;
      if (sop) begin
         scan_phase = SCAN_HEADER;
         header_pos = '0;
         objects_left = '0;
         indexes_left = '0;
      end else begin
         case (scan_phase)
            SCAN_HEADER: begin
               header_pos = header_pos + 3'd1;
               if ((header_pos == POS_VERSION && b != want_version) ||
                   (header_pos == POS_DISTRICT && b != want_district) ||
                   (header_pos == POS_INTERSECTION && b != want_intersection)) begin
                  scan_phase = SCAN_IDLE;
               end else if (header_pos == POS_COUNT) begin
                  objects_left = 4'((b & COUNT_MASK) >> 4) + 4'd1;
                  scan_phase = SCAN_TYPE;
               end
            end
            SCAN_TYPE: begin
               held = '0;
               held.object_type = b;
               scan_phase = SCAN_COUNT;
            end
            SCAN_COUNT: begin
               held.index_count = b[7:6];
               if (held.index_count > MAX_INDEXES) begin
                  scan_phase = SCAN_IDLE;
               end else if (held.index_count == 2'd0) begin
                  scan_phase = SCAN_VALUE;
               end else begin
                  indexes_left = held.index_count;
                  scan_phase = SCAN_INDEX;
               end
            end
            SCAN_INDEX: begin
               slot = held.index_count - indexes_left;
               case (slot)
                  2'd0: held.index_zero = b;
                  2'd1: held.index_one = b;
                  2'd2: held.index_two = b;
                  default: ;
               endcase
               indexes_left = indexes_left - 2'd1;
               if (indexes_left == 2'd0) scan_phase = SCAN_VALUE;
            end
            SCAN_VALUE: begin
               held.object_value = b;
               pending_records.push_back(held);
               objects_left = objects_left - 4'd1;
               scan_phase = (objects_left == 4'd0) ? SCAN_IDLE : SCAN_TYPE;
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function automatic void take_record(logic [RSP_DATA_BITS-1:0] word);
      record_type got;
      record_type want;
      got = word[RECORD_BITS-1:0];
      if (pending_records.size() == 0) begin
         $error("record %0h arrived with none expected", word);
         errors++;
      end else begin
         want = pending_records.pop_front();
         check_field("object_type", want.object_type, got.object_type);
         check_field("index_count", 8'(want.index_count), 8'(got.index_count));
         check_field("index_zero", want.index_zero, got.index_zero);
         check_field("index_one", want.index_one, got.index_one);
         check_field("index_two", want.index_two, got.index_two);
         check_field("object_value", want.object_value, got.object_value);
         check_field("padding", 8'd0, 8'(word >> RECORD_BITS));
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) take_record(rsp_tdata);
      if (stall_left == 0) stall_left = idle_length();
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(logic [7:0] b, logic sop);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= sop;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, sop);
      bytes_sent++;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_message(logic [7:0] msg[$]);
      foreach (msg[i]) send_byte(msg[i], i == 0);
   endtask

   // wait for every record, then let any byte still inside the block drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_VERSION: want_version = value;
         CSR_DISTRICT: want_district = value;
         CSR_INTERSECTION: want_intersection = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [7:0] version, logic [7:0] district,
                            logic [7:0] intersection);
      settle();
      write_reg(CSR_VERSION, version);
      write_reg(CSR_DISTRICT, district);
      write_reg(CSR_INTERSECTION, intersection);
   endtask

   function automatic void build_message(int objs, ref logic [7:0] msg[$]);
      logic [1:0] n_idx;
      msg = {};
      msg.push_back(8'($urandom));
      msg.push_back(want_version);
      repeat (3) msg.push_back(8'($urandom));
      msg.push_back(want_district);
      msg.push_back(want_intersection);
      msg.push_back(8'($urandom) & ~COUNT_MASK | 8'((objs - 1) << 4));
      repeat (objs) begin
         n_idx = 2'($urandom);
         msg.push_back(8'($urandom));
         msg.push_back({n_idx, 6'($urandom)});
         repeat (n_idx) msg.push_back(8'($urandom));
         msg.push_back(8'($urandom));
      end
   endfunction

   task automatic run_traffic(int budget);
      logic [7:0] msg[$];
      int stop_at;
      int kind;
      int pos;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(99);
         build_message($urandom_range(8, 1), msg);
         if (kind < 10) begin
            case ($urandom_range(2))
               0: pos = POS_VERSION;
               1: pos = POS_DISTRICT;
               default: pos = POS_INTERSECTION;
            endcase
            msg[pos] = msg[pos] ^ 8'($urandom_range(255, 1));
         end else if (kind < 22) begin
            msg = msg[0:$urandom_range(msg.size() - 2)];
         end else if (kind < 32) begin
            repeat ($urandom_range(6, 1)) msg.push_back(8'($urandom));
         end
         if (kind >= 92) begin
            repeat ($urandom_range(12, 1))
               send_byte(8'($urandom), $urandom_range(15) == 0);
         end else begin
            send_message(msg);
         end
      end
   endtask

   task automatic test_bytes_before_start();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   // reset settings, one object with three indexes, one trailing byte
   task automatic test_full_object();
      send_message({8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h8F,
                    8'hFF, 8'hC0, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hFF});
   endtask

   task automatic test_header_mismatch();
      send_message({8'h00, 8'h02, 8'h01});
   endtask

   // eight objects announced, cut off inside the first; next start restarts
   task automatic test_short_message();
      send_message({8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'h12});
   endtask

   task automatic test_extreme_settings();
      write_all(8'h00, 8'h00, 8'h00);
      write_reg(CSR_UNUSED, 8'hFF);
      idle_pct = 0;
      run_traffic(400);
      write_all(8'hFF, 8'hFF, 8'hFF);
      idle_pct = 30;
      run_traffic(500);
   endtask

   task automatic test_random_settings();
      write_all(8'($urandom), 8'($urandom), 8'($urandom));
      idle_pct = 60;
      run_traffic(500);
      write_all(8'($urandom), 8'($urandom), 8'($urandom));
      idle_pct = 20;
      run_traffic(500);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 30;
      test_bytes_before_start();
      test_full_object();
      test_header_mismatch();
      test_short_message();
      test_extreme_settings();
      test_random_settings();
      settle();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
